[rtl/bdm_pkg.sv]
`default_nettype none
package bdm_pkg;

  localparam logic [63:0] PI_Q32 = 64'd13493037705;
  localparam logic [63:0] MIN_S2 = 64'd43;

  localparam int FifoDepth = 4;
  localparam int FifoAw = $clog2(FifoDepth);
  localparam int SqrtStages = 32;

  localparam logic [5:0] SH_AREA = 6'd32;
  localparam logic [5:0] SH_KD = 6'd33;
  localparam logic [5:0] SH_AR = 6'd16;
  localparam logic [5:0] SH_KM = 6'd32;
  localparam logic [5:0] SH_FORCE = 6'd48;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_DENSITY = 2'd1;
  localparam logic [1:0] REG_DRAG = 2'd2;
  localparam logic [1:0] REG_MAGNUS = 2'd3;

  typedef struct packed {
    logic [7:0]       id;
    logic [2:0][31:0] vm;
    logic [2:0]       vn;
    logic [2:0][31:0] wm;
    logic [2:0]       wn;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [63:0] s2;
  } entry_t;

endpackage
`default_nettype wire

[rtl/bdm_mulq.sv]
`default_nettype none
// a*b >> sh, round half up, saturate to 64 bits; registered output
module bdm_mulq (
  input  logic        clk_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic [5:0]  sh_i,
  output logic [63:0] p_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] prod_q;
  logic [128:0] sum;
  logic [128:0] shd;

  always_comb begin
    sum = {1'b0, prod_q} + (129'd1 << (sh_i - 6'd1));
    shd = sum >> sh_i;
  end

  always_ff @(posedge clk_i) begin
    p00_q  <= a_i[31:0] * b_i[31:0];
    p01_q  <= a_i[31:0] * b_i[63:32];
    p10_q  <= a_i[63:32] * b_i[31:0];
    p11_q  <= a_i[63:32] * b_i[63:32];
    prod_q <= {64'd0, p00_q} + {32'd0, p01_q, 32'd0} + {32'd0, p10_q, 32'd0}
              + {p11_q, 64'd0};
    p_o    <= (|shd[128:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : shd[63:0];
  end

endmodule
`default_nettype wire

[rtl/bdm_coef.sv]
`default_nettype none
// Drag and Magnus gains from the shared config, recomputed continuously
module bdm_coef (
  input  logic        clk_i,
  input  logic [31:0] radius_i,
  input  logic [31:0] density_i,
  input  logic [31:0] drag_i,
  input  logic [31:0] magnus_i,
  output logic [63:0] kd_o,
  output logic [63:0] km_o,
  output logic        cn_o
);

  logic [63:0] rr_q, rc_q, cr_q;
  logic [63:0] area, ar;
  logic [31:0] cm;

  assign cn_o = magnus_i[31];
  assign cm   = magnus_i[31] ? (32'd0 - magnus_i) : magnus_i;

  always_ff @(posedge clk_i) begin
    rr_q <= radius_i * radius_i;
    rc_q <= density_i * drag_i;
    cr_q <= cm * density_i;
  end

  bdm_mulq u_area (.clk_i, .a_i(rr_q), .b_i(bdm_pkg::PI_Q32), .sh_i(bdm_pkg::SH_AREA),
                   .p_o(area));
  bdm_mulq u_kd (.clk_i, .a_i(area), .b_i(rc_q), .sh_i(bdm_pkg::SH_KD), .p_o(kd_o));
  bdm_mulq u_ar (.clk_i, .a_i(area), .b_i({32'd0, radius_i}), .sh_i(bdm_pkg::SH_AR),
                 .p_o(ar));
  bdm_mulq u_km (.clk_i, .a_i(ar), .b_i(cr_q), .sh_i(bdm_pkg::SH_KM), .p_o(km_o));

endmodule
`default_nettype wire

[rtl/bdm_front.sv]
`default_nettype none
// Takes a beat, splits vectors into sign/magnitude, drops slow or inactive balls
module bdm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          ball_id_i,
  input  logic                active_i,
  input  logic [31:0]         vel_x_i,
  input  logic [31:0]         vel_y_i,
  input  logic [31:0]         vel_z_i,
  input  logic [31:0]         spin_x_i,
  input  logic [31:0]         spin_y_i,
  input  logic [31:0]         spin_z_i,
  output logic                push_o,
  output bdm_pkg::entry_t     entry_o
);

  bdm_pkg::item_t   it1_q, it2_q, it1_d;
  logic             v1_q, v2_q;
  logic [2:0][63:0] sq_q;
  logic [2:0][31:0] vin, win;
  logic [63:0]      s2;

  always_comb begin
    vin = {vel_z_i, vel_y_i, vel_x_i};
    win = {spin_z_i, spin_y_i, spin_x_i};
    it1_d.id = ball_id_i;
    for (int i = 0; i < 3; i++) begin
      it1_d.vn[i] = vin[i][31];
      it1_d.vm[i] = vin[i][31] ? (32'd0 - vin[i]) : vin[i];
      it1_d.wn[i] = win[i][31];
      it1_d.wm[i] = win[i][31] ? (32'd0 - win[i]) : win[i];
    end
    s2 = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= take_i & active_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    it1_q <= it1_d;
    it2_q <= it1_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= it1_q.vm[i] * it1_q.vm[i];
    end
  end

  assign push_o        = v2_q && (s2 >= bdm_pkg::MIN_S2);
  assign entry_o.item  = it2_q;
  assign entry_o.s2    = s2;

endmodule
`default_nettype wire

[rtl/bdm_fifo.sv]
`default_nettype none
module bdm_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  bdm_pkg::entry_t              wdata_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output bdm_pkg::entry_t              rdata_o,
  output logic [bdm_pkg::FifoAw:0]     level_o
);

  bdm_pkg::entry_t mem_q [bdm_pkg::FifoDepth];
  logic [bdm_pkg::FifoAw-1:0] wp_q, rp_q;
  logic [bdm_pkg::FifoAw:0]   cnt_q;
  logic                       do_pop;

  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rp_q];
  assign level_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{bdm_pkg::FifoAw{1'b0}}, push_i} - {{bdm_pkg::FifoAw{1'b0}}, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

endmodule
`default_nettype wire

[rtl/bdm_isqrt.sv]
`default_nettype none
// Pipelined floor sqrt, one root bit per stage
module bdm_isqrt (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  logic [63:0]    x_i,
  input  bdm_pkg::item_t item_i,
  output logic           valid_o,
  output logic [31:0]    root_o,
  output bdm_pkg::item_t item_o
);

  localparam int N = bdm_pkg::SqrtStages;

  logic [63:0]    x_q    [N];
  logic [35:0]    rem_q  [N];
  logic [31:0]    root_q [N];
  bdm_pkg::item_t it_q   [N];
  logic [N-1:0]   vld_q;

  logic [63:0]    x_d    [N];
  logic [35:0]    rem_d  [N];
  logic [31:0]    root_d [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [63:0] xin;
      logic [35:0] rin, rsh, trial;
      logic [31:0] qin;
      xin = (k == 0) ? x_i : x_q[k-1];
      rin = (k == 0) ? 36'd0 : rem_q[k-1];
      qin = (k == 0) ? 32'd0 : root_q[k-1];
      rsh   = {rin[33:0], xin[63:62]};
      trial = {2'b00, qin, 2'b01};
      x_d[k] = {xin[61:0], 2'b00};
      if (rsh >= trial) begin
        rem_d[k]  = rsh - trial;
        root_d[k] = {qin[30:0], 1'b1};
      end else begin
        rem_d[k]  = rsh;
        root_d[k] = {qin[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      x_q[k]    <= x_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
      it_q[k]   <= (k == 0) ? item_i : it_q[(k == 0) ? 0 : k-1];
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign item_o  = it_q[N-1];

endmodule
`default_nettype wire

[rtl/bdm_back.sv]
`default_nettype none
// Speed, cross product, gain multiplies and the saturated sum
module bdm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  bdm_pkg::entry_t entry_i,
  input  logic [63:0]     kd_i,
  input  logic [63:0]     km_i,
  input  logic            cn_i,
  output logic            done_o,
  output logic [7:0]      ball_out_id_o,
  output logic [31:0]     force_x_o,
  output logic [31:0]     force_y_o,
  output logic [31:0]     force_z_o
);

  function automatic logic [64:0] sm_add(input logic na, input logic [63:0] ma,
                                         input logic nb, input logic [63:0] mb);
    logic [64:0] s;
    logic [63:0] r;
    logic        n;
    s = {1'b0, ma} + {1'b0, mb};
    if (na == nb) begin
      r = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
      n = na;
    end else if (ma >= mb) begin
      r = ma - mb;
      n = na;
    end else begin
      r = mb - ma;
      n = nb;
    end
    if (r == 64'd0) n = 1'b0;
    return {n, r};
  endfunction

  function automatic logic [31:0] sat_out(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    if (neg) begin
      c = (m > 64'h8000_0000) ? 64'h8000_0000 : m;
      return 32'd0 - c[31:0];
    end
    c = (m > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : m;
    return c[31:0];
  endfunction

  logic           sv;
  logic [31:0]    speed;
  bdm_pkg::item_t sit;

  bdm_isqrt u_sqrt (
    .clk_i, .rst_ni, .valid_i, .x_i(entry_i.s2), .item_i(entry_i.item),
    .valid_o(sv), .root_o(speed), .item_o(sit)
  );

  // stage A: raw products
  logic             va_q;
  logic [7:0]       ida_q;
  logic [2:0]       vna_q, na_q, nb_q;
  logic [2:0][63:0] vs_q, pa_q, pb_q;
  // stage B: cross product in sign/magnitude
  logic             vb_q;
  logic [7:0]       idb_q;
  logic [2:0]       vnb_q, xnb_q;
  logic [2:0][63:0] vsb_q, xmb_q;
  logic [2:0][64:0] xs;
  // sideband delayed alongside the gain multipliers
  logic [2:0]       vc_q;
  logic [7:0]       idc_q [3];
  logic [2:0]       vnc_q [3];
  logic [2:0]       xnc_q [3];
  logic [2:0][63:0] dm, mm;
  logic [2:0][31:0] fo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = sm_add(na_q[i], pa_q[i], nb_q[i], pb_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      logic        mn, dn;
      logic [64:0] t;
      mn = (cn_i != xnc_q[2][i]) && (mm[i] != 64'd0);
      dn = !vnc_q[2][i] && (dm[i] != 64'd0);
      t  = sm_add(dn, dm[i], mn, mm[i]);
      fo[i] = sat_out(t[64], t[63:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= '0;
      done_o <= 1'b0;
    end else begin
      va_q   <= sv;
      vb_q   <= va_q;
      vc_q   <= {vc_q[1:0], vb_q};
      done_o <= vc_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    ida_q <= sit.id;
    vna_q <= sit.vn;
    for (int i = 0; i < 3; i++) begin
      vs_q[i] <= sit.vm[i] * speed;
      pa_q[i] <= sit.wm[(i + 1) % 3] * sit.vm[(i + 2) % 3];
      pb_q[i] <= sit.wm[(i + 2) % 3] * sit.vm[(i + 1) % 3];
      na_q[i] <= sit.wn[(i + 1) % 3] ^ sit.vn[(i + 2) % 3];
      nb_q[i] <= !(sit.wn[(i + 2) % 3] ^ sit.vn[(i + 1) % 3]);
    end
    idb_q <= ida_q;
    vnb_q <= vna_q;
    vsb_q <= vs_q;
    for (int i = 0; i < 3; i++) begin
      xnb_q[i] <= xs[i][64];
      xmb_q[i] <= xs[i][63:0];
    end
    idc_q[0] <= idb_q;
    vnc_q[0] <= vnb_q;
    xnc_q[0] <= xnb_q;
    for (int k = 1; k < 3; k++) begin
      idc_q[k] <= idc_q[k-1];
      vnc_q[k] <= vnc_q[k-1];
      xnc_q[k] <= xnc_q[k-1];
    end
    ball_out_id_o <= idc_q[2];
    force_x_o     <= fo[0];
    force_y_o     <= fo[1];
    force_z_o     <= fo[2];
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    bdm_mulq u_drag (.clk_i, .a_i(vsb_q[i]), .b_i(kd_i), .sh_i(bdm_pkg::SH_FORCE),
                     .p_o(dm[i]));
    bdm_mulq u_mag (.clk_i, .a_i(xmb_q[i]), .b_i(km_i), .sh_i(bdm_pkg::SH_FORCE),
                    .p_o(mm[i]));
  end

endmodule
`default_nettype wire

[rtl/ball_drag_magnus_force_top.sv]
`default_nettype none
// A ball passes the front stages and queue, the 32 sqrt stages, then the products,
// cross sum, gain multiply and output register before the done strobe.
// Throughput: one ball per cycle unless busy; pipelined root and multipliers set it.
// Results cannot be stalled by the receiver; busy only guards the short queue.
// Reset clears all valid flags and loads the config defaults; gains settle
// once a config write has passed the coef registers and multipliers.
module ball_drag_magnus_force_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  ball_id_i,
  input  logic        active_i,
  input  logic [31:0] vel_x_i,
  input  logic [31:0] vel_y_i,
  input  logic [31:0] vel_z_i,
  input  logic [31:0] spin_x_i,
  input  logic [31:0] spin_y_i,
  input  logic [31:0] spin_z_i,
  output logic        done_o,
  output logic [7:0]  ball_out_id_o,
  output logic [31:0] force_x_o,
  output logic [31:0] force_y_o,
  output logic [31:0] force_z_o
);

  logic [31:0] radius_q, density_q, drag_q, magnus_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= 32'd0;
      density_q <= 32'd80282;
      drag_q    <= 32'd0;
      magnus_q  <= 32'd0;
    end else if (wr) begin
      unique case (paddr[3:2])
        bdm_pkg::REG_RADIUS:  radius_q  <= pwdata;
        bdm_pkg::REG_DENSITY: density_q <= pwdata;
        bdm_pkg::REG_DRAG:    drag_q    <= pwdata;
        bdm_pkg::REG_MAGNUS:  magnus_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bdm_pkg::REG_RADIUS:  prdata = radius_q;
      bdm_pkg::REG_DENSITY: prdata = density_q;
      bdm_pkg::REG_DRAG:    prdata = drag_q;
      bdm_pkg::REG_MAGNUS:  prdata = magnus_q;
      default:              prdata = 32'd0;
    endcase
  end

  logic [63:0] kd, km;
  logic        cn;

  bdm_coef u_coef (
    .clk_i, .radius_i(radius_q), .density_i(density_q), .drag_i(drag_q),
    .magnus_i(magnus_q), .kd_o(kd), .km_o(km), .cn_o(cn)
  );

  logic                        push, qv;
  bdm_pkg::entry_t             wentry, rentry;
  logic [bdm_pkg::FifoAw:0]    level;

  // two beats may still be in the front stages
  assign busy = level > (bdm_pkg::FifoDepth[bdm_pkg::FifoAw:0] - 3'(3));

  bdm_front u_front (
    .clk_i, .rst_ni, .take_i(start & ~busy), .ball_id_i, .active_i,
    .vel_x_i, .vel_y_i, .vel_z_i, .spin_x_i, .spin_y_i, .spin_z_i,
    .push_o(push), .entry_o(wentry)
  );

  bdm_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wentry), .pop_i(qv),
    .valid_o(qv), .rdata_o(rentry), .level_o(level)
  );

  bdm_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .entry_i(rentry), .kd_i(kd), .km_i(km), .cn_i(cn),
    .done_o, .ball_out_id_o, .force_x_o, .force_y_o, .force_z_o
  );

endmodule
`default_nettype wire

[tb/tb_ball_drag_magnus_force_top.sv]
`default_nettype none
module tb_ball_drag_magnus_force_top;

  localparam int LATENCY = 42;
  localparam int SETTLE = 60;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0]  id;
    logic        active;
    logic [31:0] vx, vy, vz, wx, wy, wz;
  } ball_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] fx, fy, fz;
  } force_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  ball_id_i = '0;
  logic        active_i = 1'b0;
  logic [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [31:0] spin_x_i = '0, spin_y_i = '0, spin_z_i = '0;
  logic        done_o;
  logic [7:0]  ball_out_id_o;
  logic [31:0] force_x_o, force_y_o, force_z_o;

  ball_drag_magnus_force_top u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .ball_id_i, .active_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .spin_x_i, .spin_y_i, .spin_z_i, .done_o, .ball_out_id_o,
    .force_x_o, .force_y_o, .force_z_o
  );

  always #4 clk_i = ~clk_i;

  // shadow of the config registers
  logic [31:0] radius_q = 32'd0, density_q = 32'd80282, drag_q = 32'd0, magnus_q = 32'd0;

  ball_t  pending_balls[$];
  force_t expected_forces[$];
  int     errors = 0;
  int     idle_cycles = 0;
  int     gap_left = 0;
  bit     stim_done = 1'b0;

  task automatic queue_ball(ball_t b);
    pending_balls.insert(pending_balls.size(), b);
  endtask

  // a*b >> s, rounded half up, saturated to 64 bits
  function automatic logic [63:0] mul_rnd(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    p = p >> s;
    return (p[127:64] != 0) ? MAX64 : p[63:0];
  endfunction

  function automatic logic [31:0] abs32(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // sign-magnitude add, magnitude saturated
  function automatic logic [64:0] sm_sum(logic na, logic [63:0] ma, logic nb, logic [63:0] mb);
    logic [64:0] r;
    logic        n;
    if (na == nb) begin
      r = {1'b0, ma} + {1'b0, mb};
      if (r[64]) r = {1'b0, MAX64};
      n = na;
    end else if (ma >= mb) begin
      r = {1'b0, ma - mb};
      n = na;
    end else begin
      r = {1'b0, mb - ma};
      n = nb;
    end
    if (r[63:0] == 0) n = 1'b0;
    return {n, r[63:0]};
  endfunction

  function automatic logic [31:0] clamp_force(logic neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return ~m[31:0] + 32'd1;
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  task automatic predict_force(ball_t b);
    logic [31:0] v[3], w[3], vm[3], wm[3];
    logic        vn[3], wn[3];
    logic [63:0] s2, speed, area, kd, km, r, xm, dm, mm;
    logic [64:0] x, t;
    logic [31:0] f[3];
    logic        mn;
    force_t      e;
    int          a, c;
    if (!b.active) return;
    v = '{b.vx, b.vy, b.vz};
    w = '{b.wx, b.wy, b.wz};
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      vn[i] = v[i][31]; vm[i] = abs32(v[i]);
      wn[i] = w[i][31]; wm[i] = abs32(w[i]);
      s2 += {32'd0, vm[i]} * {32'd0, vm[i]};
    end
    if (s2 < bdm_pkg::MIN_S2) return;
    speed = root64(s2);
    r = {32'd0, radius_q};
    area = mul_rnd(r * r, bdm_pkg::PI_Q32, 32);
    kd = mul_rnd(area, {32'd0, density_q} * {32'd0, drag_q}, 33);
    km = mul_rnd(mul_rnd(area, r, 16), {32'd0, abs32(magnus_q)} * {32'd0, density_q}, 32);
    for (int i = 0; i < 3; i++) begin
      a = (i + 1) % 3;
      c = (i + 2) % 3;
      x = sm_sum(wn[a] != vn[c], {32'd0, wm[a]} * {32'd0, vm[c]},
                 !(wn[c] != vn[a]), {32'd0, wm[c]} * {32'd0, vm[a]});
      xm = x[63:0];
      dm = mul_rnd({32'd0, vm[i]} * speed, kd, 48);
      mm = mul_rnd(xm, km, 48);
      mn = (magnus_q[31] != x[64]) && mm != 0;
      t = sm_sum(!vn[i] && dm != 0, dm, mn, mm);
      f[i] = clamp_force(t[64], t[63:0]);
    end
    e.id = b.id;
    e.fx = f[0]; e.fy = f[1]; e.fz = f[2];
    expected_forces.insert(expected_forces.size(), e);
  endtask

  // driver
  always @(posedge clk_i) begin : drv
    int gap;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_force(pending_balls.pop_front());
        gap = $urandom_range(0, 9);
        if (gap == 0 && pending_balls.size() != 0) begin
          ball_id_i <= pending_balls[0].id;
          active_i <= pending_balls[0].active;
          vel_x_i <= pending_balls[0].vx;
          vel_y_i <= pending_balls[0].vy;
          vel_z_i <= pending_balls[0].vz;
          spin_x_i <= pending_balls[0].wx;
          spin_y_i <= pending_balls[0].wy;
          spin_z_i <= pending_balls[0].wz;
          start <= 1'b1;
        end else begin
          gap_left <= gap;
          start <= 1'b0;
        end
      end else if (!start && pending_balls.size() != 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else begin
          ball_id_i <= pending_balls[0].id;
          active_i <= pending_balls[0].active;
          vel_x_i <= pending_balls[0].vx;
          vel_y_i <= pending_balls[0].vy;
          vel_z_i <= pending_balls[0].vz;
          spin_x_i <= pending_balls[0].wx;
          spin_y_i <= pending_balls[0].wy;
          spin_z_i <= pending_balls[0].wz;
          start <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_forces.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: id=%0d", ball_out_id_o);
      end else begin
        force_t e;
        e = expected_forces.pop_front();
        if (e.id !== ball_out_id_o || e.fx !== force_x_o || e.fy !== force_y_o ||
            e.fz !== force_z_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp id=%0d f=%h %h %h, got id=%0d f=%h %h %h",
                     e.id, e.fx, e.fy, e.fz, ball_out_id_o, force_x_o, force_y_o,
                     force_z_o);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || pending_balls.size() == 0 && stim_done)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bdm_pkg::REG_RADIUS:  radius_q = val;
      bdm_pkg::REG_DENSITY: density_q = val;
      bdm_pkg::REG_DRAG:    drag_q = val;
      bdm_pkg::REG_MAGNUS:  magnus_q = val;
      default: ;
    endcase
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic drain();
    wait (pending_balls.size() == 0 && !start);
    wait (expected_forces.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 7) - 3;
      2: return {{14{1'b0}}, 18'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic ball_t rand_ball();
    ball_t b;
    b.id = 8'($urandom);
    b.active = ($urandom_range(0, 9) != 0);
    b.vx = rand_vel(); b.vy = rand_vel(); b.vz = rand_vel();
    b.wx = rand_vel(); b.wy = rand_vel(); b.wz = rand_vel();
    return b;
  endfunction

  initial begin
    ball_t b;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset config, extremes, tiny speeds, inactive
    queue_ball('{8'd0, 1'b0, 32'h10000, 0, 0, 0, 0, 0});
    queue_ball('{8'd255, 1'b1, 32'd6, 32'd3, 32'd1, 0, 0, 0});
    queue_ball('{8'd1, 1'b1, 32'd7, 0, 0, 0, 0, 0});
    drain();
    reg_write(bdm_pkg::REG_RADIUS, 32'h0000_1200);
    reg_write(bdm_pkg::REG_DRAG, 32'h0000_7333);
    reg_write(bdm_pkg::REG_MAGNUS, 32'h0000_4000);
    queue_ball('{8'd2, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
    queue_ball('{8'd3, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    queue_ball('{8'd4, 1'b1, 32'h000A_0000, 0, 32'hFFFB_0000,
                 0, 32'h0064_0000, 0});
    queue_ball('{8'd5, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 0, 32'h1});
    drain();
    reg_write(bdm_pkg::REG_RADIUS, 32'hFFFF_FFFF);
    reg_write(bdm_pkg::REG_DENSITY, 32'hFFFF_FFFF);
    reg_write(bdm_pkg::REG_DRAG, 32'hFFFF_FFFF);
    reg_write(bdm_pkg::REG_MAGNUS, 32'h8000_0000);
    queue_ball('{8'd6, 1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h1,
                 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    queue_ball('{8'd7, 1'b1, 32'h8000_0000, 0, 0, 0, 0, 32'h8000_0000});
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          reg_write(bdm_pkg::REG_RADIUS, 32'h0000_0B00);
          reg_write(bdm_pkg::REG_DENSITY, 32'd80282);
          reg_write(bdm_pkg::REG_DRAG, 32'h0000_8000);
          reg_write(bdm_pkg::REG_MAGNUS, 32'h0000_0000);
        end
        1: reg_write(bdm_pkg::REG_MAGNUS, 32'hFFFF_C000);
        5: begin
          reg_write(bdm_pkg::REG_RADIUS, 32'd0);
          reg_write(bdm_pkg::REG_DENSITY, 32'd0);
          reg_write(bdm_pkg::REG_DRAG, 32'd0);
          reg_write(bdm_pkg::REG_MAGNUS, 32'h7FFF_FFFF);
        end
        default: begin
          reg_write(bdm_pkg::REG_RADIUS, $urandom_range(0, 32'h0004_0000));
          reg_write(bdm_pkg::REG_DENSITY, $urandom);
          reg_write(bdm_pkg::REG_DRAG, $urandom_range(0, 32'h0004_0000));
          reg_write(bdm_pkg::REG_MAGNUS, $urandom);
        end
      endcase
      for (int n = 0; n < 175; n++) begin
        b = rand_ball();
        queue_ball(b);
      end
      drain();
    end
    stim_done = 1'b1;

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
